>>> rtl/core/swm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the star-closure function for the star wildcard name matcher.
// No dependencies; used by every module in rtl/core.
package swm_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int CHAR_W            = 8;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_IDX_W         = 3;
    localparam int LEN_W             = 6;
    localparam int CHARS_PER_REG     = CFG_DATA_W / CHAR_W;
    localparam int NUM_CHAR_REGS     = (MAX_PATTERN_BYTES + CHARS_PER_REG - 1) / CHARS_PER_REG;
    localparam int POS_W             = MAX_PATTERN_BYTES + 1;
    localparam int CLOSE_LEVELS      = $clog2(POS_W);
    localparam int OUT_DATA_W        = 8;

    localparam logic [CHAR_W-1:0] STAR_BYTE = 8'h2A;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd4;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [POS_W-1:0]  live_t;

    typedef struct packed {
        logic [MAX_PATTERN_BYTES-1:0][CHAR_W-1:0] chars;
        logic [MAX_PATTERN_BYTES-1:0]             star_en;
        logic [MAX_PATTERN_BYTES-1:0]             use_en;
        logic [LEN_W-1:0]                         len;
    } pattern_t;

    // Spread live positions forward across runs of stars. Parallel prefix:
    // bit j is live if live[j], or prop[j] and bit j-1 ends up live.
    function automatic live_t star_close(input live_t live, input live_t prop);
        live_t g;
        live_t p;
        live_t g_n;
        live_t p_n;
        g = live;
        p = prop;
        for (int lvl = 0; lvl < CLOSE_LEVELS; lvl++)
        begin
            g_n = g | (p & (g << (1 << lvl)));
            p_n = p & (p << (1 << lvl));
            g   = g_n;
            p   = p_n;
        end
        return g;
    endfunction

endpackage

>>> rtl/core/swm_cfg.sv
`timescale 1ns / 1ps
// Pattern configuration registers and per-position decode (star, in-use flags).
// Depends on swm_pkg.
module swm_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [swm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output swm_pkg::pattern_t                   pattern
);

    logic [swm_pkg::CFG_DATA_W-1:0] chars_reg [swm_pkg::NUM_CHAR_REGS];
    logic [swm_pkg::LEN_W-1:0]      len_reg;
    logic [swm_pkg::LEN_W-1:0]      len_used;

    for (genvar r = 0; r < swm_pkg::NUM_CHAR_REGS; r++)
    begin : g_chars
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                chars_reg[r] <= '0;
            end
            else if (cfg_valid &&
                     cfg_index == swm_pkg::REG_CHARS_0 + swm_pkg::CFG_IDX_W'(r))
            begin
                chars_reg[r] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_valid && cfg_index == swm_pkg::REG_LENGTH)
        begin
            len_reg <= cfg_data[swm_pkg::LEN_W-1:0];
        end
    end

    // Clamp an oversized length to the pattern capacity
    assign len_used = (len_reg > swm_pkg::LEN_W'(swm_pkg::MAX_PATTERN_BYTES)) ?
                      swm_pkg::LEN_W'(swm_pkg::MAX_PATTERN_BYTES) : len_reg;

    always_comb
    begin
        pattern.len = len_used;
        for (int i = 0; i < swm_pkg::MAX_PATTERN_BYTES; i++)
        begin
            pattern.chars[i] = chars_reg[i / swm_pkg::CHARS_PER_REG]
                               [(i % swm_pkg::CHARS_PER_REG) * swm_pkg::CHAR_W +: swm_pkg::CHAR_W];
            pattern.use_en[i]  = swm_pkg::LEN_W'(i) < len_used;
            pattern.star_en[i] = pattern.use_en[i] && (pattern.chars[i] == swm_pkg::STAR_BYTE);
        end
    end

endmodule

>>> rtl/core/swm_step.sv
`timescale 1ns / 1ps
// One-byte update of the live position set and the end-of-name match decision.
// Depends on swm_pkg.
module swm_step (
    input  swm_pkg::live_t    live,
    input  swm_pkg::pattern_t pattern,
    input  swm_pkg::char_t    name_char,
    input  logic              has_char,
    input  logic              last_char,
    output swm_pkg::live_t    live_next,
    output logic              matched
);

    swm_pkg::live_t                         prop;
    swm_pkg::live_t                         cur;
    swm_pkg::live_t                         consumed;
    swm_pkg::live_t                         live_mid;
    swm_pkg::live_t                         fin;
    logic [swm_pkg::MAX_PATTERN_BYTES-1:0]  stay;
    logic [swm_pkg::MAX_PATTERN_BYTES-1:0]  adv;

    // A star at position i lets a live bit reach position i+1
    assign prop = {pattern.star_en, 1'b0};
    assign cur  = swm_pkg::star_close(live, prop);

    always_comb
    begin
        for (int i = 0; i < swm_pkg::MAX_PATTERN_BYTES; i++)
        begin
            stay[i] = cur[i] && pattern.star_en[i];
            adv[i]  = cur[i] && pattern.use_en[i] && !pattern.star_en[i] &&
                      (pattern.chars[i] == name_char);
        end
    end

    assign consumed = {1'b0, stay} | {adv, 1'b0};
    assign live_mid = has_char ? consumed : live;
    assign fin      = swm_pkg::star_close(live_mid, prop);
    assign matched  = fin[pattern.len];

    // Restart at position zero after the last byte of a name
    assign live_next = last_char ? swm_pkg::live_t'(1) : live_mid;

endmodule

>>> rtl/core/star_wildcard_name_matcher_core.sv
`timescale 1ns / 1ps
// Top level of the star wildcard name matcher: input register, step logic, result register.
// Depends on swm_pkg, swm_cfg and swm_step.
//
// Usage:
//   Load the pattern through the cfg channel (cfg_ready is always high): indexes 0..3 carry
//   pattern bytes 0..31, eight per word with the lowest byte in bits 7:0; index 4 carries
//   the pattern length in bits 5:0 (values above 32 act as 32). Write only while the block
//   is idle. In the pattern, '*' matches any run of bytes, every other byte only itself.
//   Stream the name on the s_ side, one byte per word: tdata holds the byte, tuser says
//   whether the byte is real (0 with tlast high ends an empty name), tlast marks the end.
//   On each tlast word one result word leaves on the m_ side, bit 0 of tdata = matched.
// Timing:
//   A word waits in the input register, the live-position update runs while it is held there,
//   and the result lands in the output register once the last word is processed. One word is
//   taken every cycle unless a last word is held behind a waiting result; the rate is
//   set by the combinational star closure and byte compare between the two registers.
// Reset and stall:
//   Reset clears the pattern and length, empties both registers and makes only pattern
//   position zero live. While a result waits on a low m_tready, non-last words still flow;
//   the next tlast word holds in the input register until the result is taken.
module star_wildcard_name_matcher_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swm_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Name byte stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [swm_pkg::CHAR_W-1:0]        s_tdata,   // [7:0] name_char
    input  logic [0:0]                        s_tuser,   // [0] has_char
    input  logic                              s_tlast,   // last_char
    // Match result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [swm_pkg::OUT_DATA_W-1:0]    m_tdata    // [0] matched, [7:1] zero
);

    swm_pkg::pattern_t pattern;

    // Input register
    logic              in_valid_reg;
    logic              in_valid_next;
    swm_pkg::char_t    in_char_reg;
    logic              in_has_reg;
    logic              in_last_reg;

    // Live pattern positions, not closed over stars
    swm_pkg::live_t    live_reg;
    swm_pkg::live_t    live_next;

    // Result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_matched_reg;

    swm_pkg::live_t    step_live;
    logic              step_matched;
    logic              advance;
    logic              s_accept;

    assign cfg_ready = 1'b1;

    swm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pattern   (pattern)
    );

    swm_step u_step (
        .live      (live_reg),
        .pattern   (pattern),
        .name_char (in_char_reg),
        .has_char  (in_has_reg),
        .last_char (in_last_reg),
        .live_next (step_live),
        .matched   (step_matched)
    );

    // Process the held word unless it would overwrite a result still waiting
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        live_next     = advance ? step_live : live_reg;
        if (advance && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            live_reg      <= swm_pkg::live_t'(1);
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            live_reg      <= live_next;
        end
    end

    // Payload registers: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_char_reg <= s_tdata;
            in_has_reg  <= s_tuser[0];
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
        begin
            out_matched_reg <= step_matched;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(swm_pkg::OUT_DATA_W - 1){1'b0}}, out_matched_reg};

    // A processed last word always leaves a result behind
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> out_valid_reg)
        else $error("last word processed without a result");

    // A result waiting on a stalled receiver is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !(advance && in_last_reg))
        else $error("pending result overwritten");

    // Matching restarts at position zero after each name
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> live_reg == swm_pkg::live_t'(1))
        else $error("live positions not restarted after last word");

    // An empty input register always takes a word
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while input register empty");

endmodule

>>> tb/tb_star_wildcard_name_matcher_core.sv
`timescale 1ns / 1ps
// Self-checking bench for star_wildcard_name_matcher_core: loads glob patterns, streams names
// under random back-pressure and checks every match flag against an in-bench live-set model.
// Depends on swm_pkg and the core RTL only.
module tb_star_wildcard_name_matcher_core;

    // First register index that the block does not decode; writes there must be ignored
    localparam logic [swm_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = swm_pkg::REG_LENGTH + 3'd1;
    localparam int DRAIN_CYCLES      = 4;
    localparam int ITEMS_PER_MODE    = 650;
    localparam int ITEMS_PER_PATTERN = 130;

    // One name word as it travels on the s_ side
    typedef struct packed {
        swm_pkg::char_t ch;
        logic           has;
        logic           last;
    } name_word_t;

    // Tracks the live pattern positions and the match flags still owed by the block.
    class name_match_scoreboard;
        swm_pkg::char_t            pat_bytes [swm_pkg::MAX_PATTERN_BYTES];
        logic [swm_pkg::LEN_W-1:0] pat_len;
        swm_pkg::live_t            live;
        bit                        verdict_q [$];
        int                        fail_count;
        int                        results_seen;
        int                        matches_seen;

        function new();
            foreach (pat_bytes[i])
                pat_bytes[i] = '0;
            pat_len      = '0;
            live         = swm_pkg::live_t'(1);
            fail_count   = 0;
            results_seen = 0;
            matches_seen = 0;
        endfunction

        // Lengths above the pattern store act as a full pattern
        function int used_len();
            return (pat_len > swm_pkg::MAX_PATTERN_BYTES) ?
                   swm_pkg::MAX_PATTERN_BYTES : int'(pat_len);
        endfunction

        function void write_reg(logic [swm_pkg::CFG_IDX_W-1:0] idx,
                                logic [swm_pkg::CFG_DATA_W-1:0] data);
            if (int'(idx) < int'(swm_pkg::REG_CHARS_0) + swm_pkg::NUM_CHAR_REGS)
            begin
                for (int k = 0; k < swm_pkg::CHARS_PER_REG; k++)
                    pat_bytes[(int'(idx) - int'(swm_pkg::REG_CHARS_0)) * swm_pkg::CHARS_PER_REG
                              + k] = data[k*swm_pkg::CHAR_W +: swm_pkg::CHAR_W];
            end
            else if (idx == swm_pkg::REG_LENGTH)
            begin
                pat_len = data[swm_pkg::LEN_W-1:0];
            end
        endfunction

        // Walk positions low to high so a chain of stars carries a live bit all the way
        function swm_pkg::live_t spread_stars(swm_pkg::live_t v, int n);
            swm_pkg::live_t r;
            r = v;
            for (int i = 0; i < n; i++)
                if (r[i] && pat_bytes[i] == swm_pkg::STAR_BYTE)
                    r[i+1] = 1'b1;
            return r;
        endfunction

        function void note_input(name_word_t w);
            int             n;
            swm_pkg::live_t cur;
            swm_pkg::live_t nxt;
            n = used_len();
            if (w.has)
            begin
                cur = spread_stars(live, n);
                nxt = '0;
                for (int i = 0; i < n; i++)
                begin
                    if (cur[i])
                    begin
                        // a star swallows the byte and stays put; a literal must equal it
                        if (pat_bytes[i] == swm_pkg::STAR_BYTE)
                            nxt[i] = 1'b1;
                        else if (pat_bytes[i] == w.ch)
                            nxt[i+1] = 1'b1;
                    end
                end
                live = nxt;
            end
            if (w.last)
            begin
                cur = spread_stars(live, n);
                verdict_q = {verdict_q, cur[n]};
                live = swm_pkg::live_t'(1);
            end
        endfunction

        task report_mismatch(string what);
            fail_count++;
            $display("MISMATCH at %0t ns: %s", $time, what);
        endtask

        task check_result(logic [swm_pkg::OUT_DATA_W-1:0] word);
            logic want;
            if (verdict_q.size() == 0)
            begin
                report_mismatch($sformatf("result word %02h with no name outstanding", word));
            end
            else
            begin
                want = verdict_q.pop_front();
                results_seen++;
                if (want)
                    matches_seen++;
                if (word !== {{(swm_pkg::OUT_DATA_W-1){1'b0}}, want})
                    report_mismatch($sformatf("name %0d: got word %02h, expected matched=%0d",
                                              results_seen, word, want));
            end
        endtask
    endclass

    // Block ports; every input starts at a known value
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [swm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [swm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    swm_pkg::char_t                 s_tdata   = '0;
    logic [0:0]                     s_tuser   = '0;
    logic                           s_tlast   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [swm_pkg::OUT_DATA_W-1:0] m_tdata;

    name_match_scoreboard model;
    swm_pkg::char_t       pat_plan [swm_pkg::MAX_PATTERN_BYTES];
    name_word_t           name_buf [$];
    int                   send_idle_pct   = 0;
    int                   recv_idle_pct   = 0;
    int                   items_sent      = 0;
    int                   settings_loaded = 0;

    star_wildcard_name_matcher_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] name_char
        .s_tuser   (s_tuser),   // [0] has_char
        .s_tlast   (s_tlast),   // last_char
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // [0] matched, [7:1] zero
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case the block hangs or drops a result
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver: drop m_tready at random on the falling edge, at the rate of the current mode
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Take result words at the rising edge and hand them to the scoreboard
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            model.check_result(m_tdata);

    function automatic name_word_t word_of(swm_pkg::char_t ch, logic has, logic last);
        name_word_t w;
        w.ch   = ch;
        w.has  = has;
        w.last = last;
        return w;
    endfunction

    // Name bytes lean on a small alphabet so shaped names hit the pattern literals
    function automatic swm_pkg::char_t pick_char();
        swm_pkg::char_t c;
        c = swm_pkg::char_t'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85)
        begin
            case ($urandom_range(0, 3))
                0:       c = 8'h61;              // 'a'
                1:       c = 8'h62;              // 'b'
                2:       c = 8'h63;              // 'c'
                default: c = swm_pkg::STAR_BYTE; // a literal '*' in the name
            endcase
        end
        return c;
    endfunction

    // Fill name_buf with one name. Shaped names follow the pattern (stars expanded to short
    // runs) with an occasional flip, drop or insert; the rest are random junk bytes.
    function automatic void build_name(bit shaped);
        swm_pkg::char_t body [$];
        int             n;
        int             pick;
        int             at;
        body.delete();
        name_buf.delete();
        if (shaped)
        begin
            n = model.used_len();
            for (int i = 0; i < n; i++)
            begin
                if (model.pat_bytes[i] == swm_pkg::STAR_BYTE)
                begin
                    repeat ($urandom_range(0, 3))
                        body = {body, pick_char()};
                end
                else
                begin
                    body = {body, model.pat_bytes[i]};
                end
            end
            if ($urandom_range(0, 99) < 30)
            begin
                pick = $urandom_range(0, 2);
                at   = (body.size() == 0) ? 0 : $urandom_range(0, body.size() - 1);
                if (pick == 0 && body.size() != 0)
                    body[at] = body[at] ^ swm_pkg::char_t'(1 << $urandom_range(0, 7));
                else if (pick == 1 && body.size() != 0)
                    body.delete(at);
                else
                    body.insert(at, pick_char());
            end
        end
        else
        begin
            repeat ($urandom_range(0, 8))
                body = {body, swm_pkg::char_t'($urandom_range(0, 255))};
        end
        foreach (body[i])
        begin
            // now and then a blank word (no byte, not last) that must change nothing
            if ($urandom_range(0, 99) < 5)
                name_buf = {name_buf,
                            word_of(swm_pkg::char_t'($urandom_range(0, 255)), 1'b0, 1'b0)};
            name_buf = {name_buf, word_of(body[i], 1'b1, 1'b0)};
        end
        // close with a byte-less last word for empty names and now and then otherwise
        if (body.size() == 0 || $urandom_range(0, 99) < 20)
            name_buf = {name_buf,
                        word_of(swm_pkg::char_t'($urandom_range(0, 255)), 1'b0, 1'b1)};
        else
            name_buf[name_buf.size() - 1].last = 1'b1;
    endfunction

    task automatic cfg_write(logic [swm_pkg::CFG_IDX_W-1:0] idx,
                             logic [swm_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        model.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Load pat_plan into the four byte registers, then the length word
    task automatic load_pattern(logic [swm_pkg::CFG_DATA_W-1:0] len_word);
        logic [swm_pkg::CFG_DATA_W-1:0] chars_word;
        for (int r = 0; r < swm_pkg::NUM_CHAR_REGS; r++)
        begin
            for (int k = 0; k < swm_pkg::CHARS_PER_REG; k++)
                chars_word[k*swm_pkg::CHAR_W +: swm_pkg::CHAR_W] =
                    pat_plan[r*swm_pkg::CHARS_PER_REG + k];
            cfg_write(swm_pkg::REG_CHARS_0 + swm_pkg::CFG_IDX_W'(r), chars_word);
        end
        cfg_write(swm_pkg::REG_LENGTH, len_word);
        settings_loaded++;
    endtask

    // Hold each word until accepted; idle gaps go in ahead of it at the sender's rate
    task automatic send_word(name_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= w.ch;
        s_tuser  <= w.has;
        s_tlast  <= w.last;
        do
            @(posedge clk);
        while (!s_tready);
        model.note_input(w);
        items_sent++;
    endtask

    task automatic send_name();
        foreach (name_buf[i])
            send_word(name_buf[i]);
    endtask

    // Drop the stream, wait for every owed result, then let the pipeline run dry
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (model.verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic random_pattern();
        int                             len_val;
        bit                             all_stars;
        logic [swm_pkg::CFG_DATA_W-1:0] len_word;
        case ($urandom_range(0, 9))
            0:       len_val = 0;
            1:       len_val = swm_pkg::MAX_PATTERN_BYTES;
            2:       len_val = $urandom_range(swm_pkg::MAX_PATTERN_BYTES + 1,
                                              (1 << swm_pkg::LEN_W) - 1);
            default: len_val = $urandom_range(1, 12);
        endcase
        all_stars = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < swm_pkg::MAX_PATTERN_BYTES; i++)
        begin
            // bytes past the length are junk so every register bit moves
            pat_plan[i] = swm_pkg::char_t'($urandom_range(0, 255));
            if (i < len_val)
            begin
                if (all_stars || $urandom_range(0, 99) < 30)
                    pat_plan[i] = swm_pkg::STAR_BYTE;
                else if ($urandom_range(0, 99) < 85)
                    pat_plan[i] = swm_pkg::char_t'(8'h61 + $urandom_range(0, 2)); // 'a'..'c'
            end
        end
        // upper bits of the length word must be ignored
        len_word                      = {$urandom(), $urandom()};
        len_word[swm_pkg::LEN_W-1:0]  = swm_pkg::LEN_W'(len_val);
        load_pattern(len_word);
        if ($urandom_range(0, 3) == 0)
            cfg_write(REG_SPARE_FIRST + swm_pkg::CFG_IDX_W'($urandom_range(0, 2)),
                      {$urandom(), $urandom()});
    endtask

    // Hand-picked names: empty names, both byte extremes, blanks, byte-less ends,
    // dead names, a literal star in the name, and an oversized length over all stars
    task automatic directed_checks();
        // reset pattern is empty: only the empty name matches
        send_word(word_of(8'h00, 1'b0, 1'b1));
        send_word(word_of(8'hFF, 1'b1, 1'b1));
        send_word(word_of(8'h00, 1'b1, 1'b1));
        settle();

        foreach (pat_plan[i])
            pat_plan[i] = '0;
        pat_plan[0] = 8'h61;        // 'a'
        pat_plan[1] = swm_pkg::STAR_BYTE;
        pat_plan[2] = 8'h62;        // 'b'
        load_pattern(64'd3);
        send_word(word_of(8'h61, 1'b1, 1'b0));
        send_word(word_of(8'h62, 1'b1, 1'b1));
        send_word(word_of(8'h61, 1'b1, 1'b0));
        send_word(word_of(8'h00, 1'b1, 1'b0));
        send_word(word_of(8'hFF, 1'b1, 1'b0));
        send_word(word_of(8'h62, 1'b1, 1'b1));
        send_word(word_of(8'h61, 1'b1, 1'b0));
        send_word(word_of(8'h55, 1'b0, 1'b0));
        send_word(word_of(8'h62, 1'b1, 1'b1));
        // ends before the final literal: no match
        send_word(word_of(8'h61, 1'b1, 1'b0));
        send_word(word_of(8'hAA, 1'b0, 1'b1));
        // dead from the first byte, keeps consuming until last
        send_word(word_of(8'h78, 1'b1, 1'b0));
        send_word(word_of(8'h62, 1'b1, 1'b1));
        send_word(word_of(8'h61, 1'b1, 1'b0));
        send_word(word_of(swm_pkg::STAR_BYTE, 1'b1, 1'b0));
        send_word(word_of(8'h62, 1'b1, 1'b1));
        settle();

        foreach (pat_plan[i])
            pat_plan[i] = swm_pkg::STAR_BYTE;
        load_pattern(64'd63);
        send_word(word_of(8'h00, 1'b0, 1'b1));
        send_word(word_of(swm_pkg::STAR_BYTE, 1'b1, 1'b1));
        settle();
    endtask

    initial
    begin
        int mode_start;
        int pattern_start;
        model = new();
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Three modes: sender idles lightly while receiver stalls hard, then swapped,
        // then both run flat out
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 57 : 0;
            recv_idle_pct = (mode == 0) ? 57 : (mode == 1) ? 23 : 0;
            if (mode == 0)
                directed_checks();
            mode_start = items_sent;
            while (items_sent - mode_start < ITEMS_PER_MODE)
            begin
                random_pattern();
                pattern_start = items_sent;
                while (items_sent - pattern_start < ITEMS_PER_PATTERN)
                begin
                    build_name($urandom_range(0, 99) < 80);
                    send_name();
                end
                settle();
            end
        end

        $display("Streamed %0d name words over %0d pattern loads under three stall mixes,",
                 items_sent, settings_loaded);
        $display("checked %0d match flags (%0d matches), %0d mismatches.",
                 model.results_seen, model.matches_seen, model.fail_count);
        if (model.fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
